>>> src/pst_pkg.sv
// Shared constants and types of the spanning tree engine.
`default_nettype none

package pst_pkg;

  localparam int unsigned NODES      = 16;
  localparam int unsigned NODE_W     = 4;
  localparam int unsigned COST_W     = 16;
  localparam int unsigned LINK_W     = COST_W + 1;
  localparam int unsigned LINK_DEPTH = NODES * NODES;
  localparam int unsigned LINK_AW    = 2 * NODE_W;

  // Link cost that marks a missing edge, one above the largest real cost
  localparam logic [LINK_W-1:0] NO_LINK = {1'b1, {COST_W{1'b0}}};

  typedef enum logic {
    CMD_ADD = 1'b0,
    CMD_RUN = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_CMP,
    ST_ADD_WR,
    ST_RUN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_e;

  // One entry of the per-node memory
  typedef struct packed {
    logic [LINK_W-1:0] cost;
    logic [NODE_W-1:0] parent;
  } node_ent_t;

  // Relaxation stage request
  typedef struct packed {
    logic              vld;
    logic              clr;
    logic [NODE_W-1:0] idx;
    logic              in_tree;
    logic [LINK_W-1:0] cur_cost;
    logic [LINK_W-1:0] link_w;
    logic [NODE_W-1:0] pick;
  } relax_in_t;

  // Relaxation stage result
  typedef struct packed {
    logic              wr;
    node_ent_t         ent;
    logic              min_vld;
    logic [NODE_W-1:0] min_idx;
  } relax_out_t;

endpackage

`default_nettype wire

>>> src/pst_if.sv
// Handshake channels of the spanning tree engine.
`default_nettype none

interface pst_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [pst_pkg::NODE_W-1:0]     node_a;
  logic [pst_pkg::NODE_W-1:0]     node_b;
  logic [pst_pkg::COST_W-1:0]     cost;

  modport source (output valid, command, node_a, node_b, cost, input ready);
  modport sink   (input valid, command, node_a, node_b, cost, output ready);
endinterface

interface pst_out_if;
  logic                           valid;
  logic                           ready;
  logic [pst_pkg::NODE_W-1:0]     parent_node;
  logic [pst_pkg::NODE_W-1:0]     child_node;
  logic [pst_pkg::COST_W-1:0]     edge_cost;
  logic                           reached;
  logic                           last;

  modport source (output valid, parent_node, child_node, edge_cost, reached, last,
                  input ready);
  modport sink   (input valid, parent_node, child_node, edge_cost, reached, last,
                  output ready);
endinterface

`default_nettype wire

>>> src/pst_relax.sv
// Relaxation of one node against the current pick and running minimum search.
`default_nettype none

module pst_relax (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pst_pkg::relax_in_t  req_i,
  output pst_pkg::relax_out_t rsp_o
);
  import pst_pkg::*;

  logic              upd;
  logic [LINK_W-1:0] new_cost;
  logic [LINK_W-1:0] bound;
  logic              cand;
  logic              min_vld_q;
  logic [LINK_W-1:0] min_cost_q;
  logic [NODE_W-1:0] min_idx_q;

  // Lower a node's cost only on a strictly cheaper link from the pick
  assign upd = req_i.vld && !req_i.in_tree && (req_i.link_w != NO_LINK) &&
               (req_i.cur_cost > req_i.link_w);
  assign new_cost = upd ? req_i.link_w : req_i.cur_cost;

  // Track the cheapest open node, first index wins on a tie
  assign bound = min_vld_q ? min_cost_q : NO_LINK;
  assign cand  = req_i.vld && !req_i.in_tree && (new_cost < bound);

  always_comb begin
    rsp_o.wr         = upd;
    rsp_o.ent.cost   = req_i.link_w;
    rsp_o.ent.parent = req_i.pick;
    rsp_o.min_vld    = cand || min_vld_q;
    rsp_o.min_idx    = cand ? req_i.idx : min_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_vld_q <= 1'b0;
    end else if (req_i.clr) begin
      min_vld_q <= 1'b0;
    end else if (cand) begin
      min_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand) begin
      min_cost_q <= new_cost;
      min_idx_q  <= req_i.idx;
    end
  end

endmodule

`default_nettype wire

>>> src/prim_spanning_tree_engine.sv
// Top level of the minimum spanning tree engine (Prim's method, 16 nodes).
//
//   port    dir   carries
//   ------  ----  ----------------------------------------------------------
//   in_i    in    command, node_a, node_b, cost  (add edge or run from node_a)
//   out_o   out   parent_node, child_node, edge_cost, reached, last
//
// After reset all 256 link memory entries are swept to "no edge", with in_i.ready low.
// An add reads the stored cost and compares it with the new one; when the new cost is
// lower, both directions are written. A self-loop is ignored.
// A run makes one pass per tree node over the link row of the pick and the node memory,
// one read per cycle, then walks the nodes in ascending order to emit the results.
// A stalled out_o holds the result register; the result walk waits, nothing is lost.
`default_nettype none

module prim_spanning_tree_engine (
  input  logic  clk_i,
  input  logic  rst_ni,
  pst_in_if.sink    in_i,
  pst_out_if.source out_o
);
  import pst_pkg::*;

  state_e            state_q, state_d;
  logic [LINK_AW-1:0] clr_q;
  logic [NODE_W:0]   idx_q;
  logic [NODE_W-1:0] src_q, pick_q, edge_a_q, edge_b_q;
  logic [COST_W-1:0] edge_c_q;
  logic [NODES-1:0]  present_q, in_tree_q, touched_q;
  logic              st_vld_q;
  logic [NODE_W-1:0] st_idx_q;

  logic              acc, is_add, is_self, lower, issue, pass_end;
  logic [NODE_W-1:0] jdx;
  logic              j_last, qual, slot_free, load;
  logic [NODES-1:0]  emit_mask, above_mask;

  // Link memory ports
  logic [LINK_W-1:0] link_mem [LINK_DEPTH];
  logic              link_we, link_re;
  logic [LINK_AW-1:0] link_wa, link_ra;
  logic [LINK_W-1:0] link_wd, link_rd_q;

  // Node memory ports
  node_ent_t         node_mem [NODES];
  logic              node_we, node_re;
  logic [NODE_W-1:0] node_wa, node_ra;
  node_ent_t         node_wd, node_rd_q;

  relax_in_t         rx_req;
  relax_out_t        rx_rsp;

  logic              out_vld_q;
  logic [NODE_W-1:0] out_par_q, out_child_q;
  logic [COST_W-1:0] out_cost_q;
  logic              out_reached_q, out_last_q;

  // Decode the input side
  assign in_i.ready = (state_q == ST_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign is_add     = (in_i.command == CMD_ADD);
  assign is_self    = (in_i.node_a == in_i.node_b);
  assign lower      = ({1'b0, edge_c_q} < link_rd_q);

  // Pass and result walk control
  assign issue     = (state_q == ST_RUN) && !idx_q[NODE_W];
  assign pass_end  = st_vld_q && (st_idx_q == NODE_W'(NODES - 1));
  assign jdx       = idx_q[NODE_W-1:0];
  assign j_last    = (jdx == NODE_W'(NODES - 1));
  assign emit_mask = present_q & ~(NODES'(1) << src_q);
  assign above_mask = {NODES{1'b1}} << jdx << 1;
  assign qual      = present_q[jdx] && (jdx != src_q);
  assign slot_free = !out_vld_q || out_o.ready;
  assign load      = (state_q == ST_EMIT_WR) && slot_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == {LINK_AW{1'b1}}) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc) begin
          if (!is_add) state_d = ST_RUN;
          else if (!is_self) state_d = ST_ADD_CMP;
        end
      end
      ST_ADD_CMP: begin
        state_d = lower ? ST_ADD_WR : ST_IDLE;
      end
      ST_ADD_WR: begin
        state_d = ST_IDLE;
      end
      ST_RUN: begin
        if (pass_end && !rx_rsp.min_vld) state_d = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        if (qual) state_d = ST_EMIT_WR;
        else if (j_last) state_d = ST_IDLE;
      end
      ST_EMIT_WR: begin
        if (slot_free) state_d = j_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    link_we = 1'b0;
    link_wa = clr_q;
    link_wd = NO_LINK;
    link_re = 1'b0;
    link_ra = {in_i.node_a, in_i.node_b};
    node_re = 1'b0;
    node_ra = jdx;
    case (state_q)
      ST_CLEAR: begin
        link_we = 1'b1;
      end
      ST_IDLE: begin
        link_re = acc && is_add && !is_self;
      end
      ST_ADD_CMP: begin
        link_we = lower;
        link_wa = {edge_a_q, edge_b_q};
        link_wd = {1'b0, edge_c_q};
      end
      ST_ADD_WR: begin
        link_we = 1'b1;
        link_wa = {edge_b_q, edge_a_q};
        link_wd = {1'b0, edge_c_q};
      end
      ST_RUN: begin
        link_re = issue;
        link_ra = {pick_q, jdx};
        node_re = issue;
      end
      ST_EMIT_RD: begin
        node_re = qual;
      end
      default: ;
    endcase
  end

  // Relaxation stage on the returned read data
  always_comb begin
    rx_req.vld        = st_vld_q;
    rx_req.clr        = issue && (idx_q == '0);
    rx_req.idx        = st_idx_q;
    rx_req.in_tree    = in_tree_q[st_idx_q];
    rx_req.cur_cost   = touched_q[st_idx_q] ? node_rd_q.cost : NO_LINK;
    rx_req.link_w     = link_rd_q;
    rx_req.pick       = pick_q;
  end

  pst_relax u_relax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rx_req),
    .rsp_o  (rx_rsp)
  );

  assign node_we = rx_rsp.wr;
  assign node_wa = st_idx_q;
  assign node_wd = rx_rsp.ent;

  // Memories
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (link_re) link_rd_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) node_mem[node_wa] <= node_wd;
    if (node_re) node_rd_q <= node_mem[node_ra];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      idx_q     <= '0;
      present_q <= '0;
      in_tree_q <= '0;
      touched_q <= '0;
      st_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      st_vld_q <= issue;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      // Mark both endpoints of a real edge
      if (acc && is_add && !is_self) begin
        present_q <= present_q | (NODES'(1) << in_i.node_a) | (NODES'(1) << in_i.node_b);
      end
      // Start a run from the source
      if (acc && !is_add) begin
        in_tree_q <= NODES'(1) << in_i.node_a;
        touched_q <= '0;
        idx_q     <= '0;
      end
      if (node_we) touched_q[st_idx_q] <= 1'b1;
      case (state_q)
        ST_RUN: begin
          if (issue) idx_q <= idx_q + 1'b1;
          if (pass_end) begin
            idx_q <= '0;
            if (rx_rsp.min_vld) in_tree_q[rx_rsp.min_idx] <= 1'b1;
          end
        end
        ST_EMIT_RD: begin
          if (!qual && !j_last) idx_q <= idx_q + 1'b1;
        end
        ST_EMIT_WR: begin
          if (slot_free && !j_last) idx_q <= idx_q + 1'b1;
        end
        default: ;
      endcase
      // Hold a result until its transfer
      if (load) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    st_idx_q <= jdx;
    if (acc && is_add) begin
      edge_a_q <= in_i.node_a;
      edge_b_q <= in_i.node_b;
      edge_c_q <= in_i.cost;
    end
    if (acc && !is_add) begin
      src_q  <= in_i.node_a;
      pick_q <= in_i.node_a;
    end
    if ((state_q == ST_RUN) && pass_end && rx_rsp.min_vld) pick_q <= rx_rsp.min_idx;
    if (load) begin
      out_child_q   <= jdx;
      out_reached_q <= in_tree_q[jdx];
      out_par_q     <= in_tree_q[jdx] ? node_rd_q.parent : '0;
      out_cost_q    <= in_tree_q[jdx] ? node_rd_q.cost[COST_W-1:0] : {COST_W{1'b1}};
      out_last_q    <= ~|(emit_mask & above_mask);
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.parent_node = out_par_q;
  assign out_o.child_node  = out_child_q;
  assign out_o.edge_cost   = out_cost_q;
  assign out_o.reached     = out_reached_q;
  assign out_o.last        = out_last_q;

  // The pick of a pass is always part of the tree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> in_tree_q[pick_q])
    else $error("pick not in tree during pass");

  // A node memory write never lands on a tree node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_we |-> !in_tree_q[node_wa])
    else $error("relaxation wrote a tree node");

  // The next pick comes from outside the tree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pass_end && rx_rsp.min_vld) |-> !in_tree_q[rx_rsp.min_idx])
    else $error("next pick already in tree");

  // A reached node was written during the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_tree_q[jdx] && (jdx != src_q)) |-> touched_q[jdx])
    else $error("reached node without a stored cost");

  // The link memory is never written during a pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !link_we)
    else $error("link write during pass");

endmodule

`default_nettype wire

>>> bench/prim_spanning_tree_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the spanning tree engine: directed and random graph traffic.

module prim_spanning_tree_engine_tb;
  import pst_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 190;

  // One command for the engine; hold_off pauses the sender until no result is due
  typedef struct {
    cmd_e              command;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [COST_W-1:0] cost;
    bit                hold_off;
  } graph_cmd_t;

  typedef struct packed {
    logic [NODE_W-1:0] parent_node;
    logic [NODE_W-1:0] child_node;
    logic [COST_W-1:0] edge_cost;
    logic              reached;
    logic              last;
  } tree_edge_t;

  logic clk_i;
  logic rst_ni;

  pst_in_if  in_if ();
  pst_out_if out_if ();

  prim_spanning_tree_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  graph_cmd_t        cmd_backlog[$];
  tree_edge_t        tree_edges_due[$];
  logic [LINK_W-1:0] link_w [LINK_DEPTH];
  logic              node_seen [NODES];
  int unsigned       mismatches = 0;
  logic              drained;
  int unsigned       gap_left = 0;
  int unsigned       burst_left = 1;
  int unsigned       rx_mode = 0;
  int unsigned       rx_left = 0;
  int unsigned       rx_phase = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Update the graph copy on an add, or grow the tree and queue its edges on a run
  function automatic void apply_graph_cmd(cmd_e command, logic [NODE_W-1:0] node_a,
                                          logic [NODE_W-1:0] node_b,
                                          logic [COST_W-1:0] cost);
    logic [LINK_W-1:0] best [NODES];
    logic [NODE_W-1:0] via [NODES];
    logic              taken [NODES];
    logic [LINK_W-1:0] low;
    logic [LINK_W-1:0] w;
    int                pick;
    int                emitted;
    tree_edge_t        e;
    if (command == CMD_ADD) begin
      // Self-loops leave the graph untouched
      if (node_a != node_b) begin
        if ({1'b0, cost} < link_w[int'(node_a) * NODES + int'(node_b)]) begin
          link_w[int'(node_a) * NODES + int'(node_b)] = {1'b0, cost};
          link_w[int'(node_b) * NODES + int'(node_a)] = {1'b0, cost};
        end
        node_seen[node_a] = 1'b1;
        node_seen[node_b] = 1'b1;
      end
    end else begin
      for (int i = 0; i < NODES; i++) begin
        best[i]  = NO_LINK;
        via[i]   = '0;
        taken[i] = 1'b0;
      end
      best[node_a] = '0;
      // Take the cheapest open node (lowest index on a tie), then relax its row
      for (int round = 0; round < NODES; round++) begin
        pick = -1;
        low  = NO_LINK;
        for (int i = 0; i < NODES; i++) begin
          if (!taken[i] && best[i] < low) begin
            low  = best[i];
            pick = i;
          end
        end
        if (pick < 0) break;
        taken[pick] = 1'b1;
        for (int i = 0; i < NODES; i++) begin
          w = link_w[pick * NODES + i];
          if (w != NO_LINK && !taken[i] && best[i] > w) begin
            best[i] = w;
            via[i]  = NODE_W'(pick);
          end
        end
      end
      // Emit every present node but the source, ascending
      emitted = 0;
      for (int i = 0; i < NODES; i++) begin
        if (node_seen[i] && i != int'(node_a)) begin
          e.parent_node = taken[i] ? via[i] : '0;
          e.child_node  = NODE_W'(i);
          e.edge_cost   = taken[i] ? best[i][COST_W-1:0] : '1;
          e.reached     = taken[i];
          e.last        = 1'b0;
          tree_edges_due = {tree_edges_due, e};
          emitted++;
        end
      end
      if (emitted > 0) tree_edges_due[tree_edges_due.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void push_cmd(cmd_e command, int unsigned node_a, int unsigned node_b,
                                   int unsigned cost, bit hold_off);
    graph_cmd_t c;
    c.command  = command;
    c.node_a   = NODE_W'(node_a);
    c.node_b   = NODE_W'(node_b);
    c.cost     = COST_W'(cost);
    c.hold_off = hold_off;
    cmd_backlog = {cmd_backlog, c};
  endfunction

  // Sender: present the oldest pending command in bursts, drop it on transfer
  always @(posedge clk_i or negedge rst_ni) begin
    logic took;
    logic send;
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.command <= CMD_ADD;
      in_if.node_a  <= '0;
      in_if.node_b  <= '0;
      in_if.cost    <= '0;
    end else begin
      took = in_if.valid && in_if.ready;
      if (took) void'(cmd_backlog.pop_front());
      if (!in_if.valid || took) begin
        send = cmd_backlog.size() != 0 && gap_left == 0;
        if (send && cmd_backlog[0].hold_off) send = drained && !took;
        if (send) begin
          in_if.valid   <= 1'b1;
          in_if.command <= cmd_backlog[0].command;
          in_if.node_a  <= cmd_backlog[0].node_a;
          in_if.node_b  <= cmd_backlog[0].node_b;
          in_if.cost    <= cmd_backlog[0].cost;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_if.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // Receiver: check each result transfer, predict from each command transfer, stall
  always @(posedge clk_i or negedge rst_ni) begin
    tree_edge_t want;
    logic       rdy;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      drained      <= 1'b1;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (tree_edges_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual child %0d", $time,
                   out_if.child_node);
        end else begin
          want = tree_edges_due.pop_front();
          check_field("parent_node", want.parent_node, out_if.parent_node);
          check_field("child_node", want.child_node, out_if.child_node);
          check_field("edge_cost", want.edge_cost, out_if.edge_cost);
          check_field("reached", want.reached, out_if.reached);
          check_field("last", want.last, out_if.last);
        end
      end
      if (in_if.valid && in_if.ready) begin
        apply_graph_cmd(cmd_e'(in_if.command), in_if.node_a, in_if.node_b, in_if.cost);
      end
      drained <= tree_edges_due.size() == 0;

      // Stall pattern: free-running, coin flips, one in four, long stalls
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(10, 80);
      end else begin
        rx_left--;
      end
      rx_phase++;
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = $urandom_range(0, 1);
        2:       rdy = (rx_phase % 4) == 0;
        default: rdy = $urandom_range(0, 15) == 0;
      endcase
      out_if.ready <= rdy;
    end
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("prim_spanning_tree_engine_tb: errors");
    $finish;
  end

  initial begin
    int unsigned span;
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned n_add;
    int unsigned n_run;
    int unsigned round;
    int unsigned random_base;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.command = CMD_ADD;
    in_if.node_a  = '0;
    in_if.node_b  = '0;
    in_if.cost    = '0;
    out_if.ready  = 1'b0;
    for (int i = 0; i < LINK_DEPTH; i++) link_w[i] = NO_LINK;
    for (int i = 0; i < NODES; i++) node_seen[i] = 1'b0;

    // Directed: empty graph, self-loop, repeated pair, ties, cost extremes, isolated source
    push_cmd(CMD_RUN, 0, 0, 0, 1'b0);          // empty graph gives no result
    push_cmd(CMD_ADD, 3, 3, 5, 1'b0);          // self-loop, ignored
    push_cmd(CMD_RUN, 3, 0, 0, 1'b1);          // still nothing present
    push_cmd(CMD_ADD, 0, 1, 9, 1'b0);
    push_cmd(CMD_ADD, 1, 0, 12, 1'b0);         // repeated pair, higher cost kept out
    push_cmd(CMD_ADD, 0, 1, 2, 1'b0);          // repeated pair, lower cost wins
    push_cmd(CMD_ADD, 1, 2, 65535, 1'b0);
    push_cmd(CMD_ADD, 2, 3, 0, 1'b0);
    push_cmd(CMD_ADD, 0, 6, 2, 1'b0);          // same cost as 0-1, lowest index first
    push_cmd(CMD_ADD, 15, 14, 65535, 1'b0);    // separate island
    push_cmd(CMD_ADD, 5, 10, 16'hAAAA, 1'b0);
    push_cmd(CMD_ADD, 10, 5, 16'h5555, 1'b0);
    push_cmd(CMD_RUN, 0, 15, 65535, 1'b0);
    push_cmd(CMD_RUN, 15, 0, 0, 1'b0);         // max-cost link reached
    push_cmd(CMD_RUN, 7, 0, 0, 1'b0);          // source not present, all unreached
    push_cmd(CMD_RUN, 1, 0, 0, 1'b0);
    push_cmd(CMD_ADD, 6, 9, 4, 1'b1);
    push_cmd(CMD_ADD, 9, 2, 4, 1'b0);          // equal offer must not replace
    push_cmd(CMD_ADD, 6, 2, 4, 1'b0);
    push_cmd(CMD_RUN, 0, 0, 0, 1'b0);
    push_cmd(CMD_ADD, 14, 13, 1, 1'b0);
    push_cmd(CMD_RUN, 13, 0, 0, 1'b0);
    push_cmd(CMD_RUN, 14, 0, 0, 1'b0);
    push_cmd(CMD_RUN, 8, 0, 0, 1'b0);

    // Random rounds: a batch of edges over a growing node span, then a few runs
    random_base = cmd_backlog.size();
    round = 0;
    while (cmd_backlog.size() < random_base + RANDOM_ITEMS) begin
      span  = (3 + 2 * round > 15) ? 15 : 3 + 2 * round;
      n_add = $urandom_range(4, 20);
      for (int k = 0; k < n_add; k++) begin
        a = $urandom_range(0, span);
        b = $urandom_range(0, span);
        if ($urandom_range(0, 19) == 0) b = a;
        case ($urandom_range(0, 3))
          0:       c = $urandom_range(0, 15);
          1:       c = $urandom_range(0, 65535);
          2:       c = $urandom_range(0, 1) ? 65535 : 0;
          default: c = $urandom_range(100, 2000);
        endcase
        push_cmd(CMD_ADD, a, b, c, k == 0 && (round % 3) == 0);
      end
      n_run = $urandom_range(1, 5);
      for (int k = 0; k < n_run; k++) begin
        push_cmd(CMD_RUN, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 65535), 1'b0);
      end
      round++;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every command to transfer and every result to arrive, then a tail
    while (cmd_backlog.size() != 0 || in_if.valid) @(negedge clk_i);
    while (tree_edges_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (tree_edges_due.size() != 0) begin
      mismatches++;
      $display("%0t: results missing, expected %0d more actual 0", $time,
               tree_edges_due.size());
    end
    if (mismatches == 0) begin
      $display("prim_spanning_tree_engine_tb: clean");
    end else begin
      $display("prim_spanning_tree_engine_tb: errors");
    end
    $finish;
  end

endmodule
